// File: rtl/core/cht_pkg.sv
// Package for the chained hash table: sizes, operation and status codes.
// No dependencies.
package cht_pkg;
   localparam int BUCKETS = 8;
   localparam int NODES = 64;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1);
   localparam int VW = 31;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_DELETE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;
endpackage

// File: rtl/core/chained_hash_table.sv
// Chained hash table top level: sequencer over head, tail and node memories.
// Depends on cht_pkg.
//
// One request at a time. Bucket = value mod BUCKETS. Insert reads the bucket head and
// tail, then scans for the lowest free node (a read then a check per node, up to NODES
// nodes), writes it, and links the new node to the old tail in an extra step when the
// chain is not empty. Search and delete read the head, then walk the chain, a memory
// read then a compare per node visited. The node memory's single read port sets the
// walk speed. The result sits in an output register; a new request is taken once it
// is transferred. After reset a clearing pass over all NODES nodes marks every node
// free while no request is accepted.
module chained_hash_table
   import cht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_func,
   input  logic [VW-1:0] req_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [9:0]    rsp_bucket
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HEAD, S_FREE_RD, S_FREE_CHK, S_INS_WR, S_INS_LINK,
      S_WALK_RD, S_WALK_CHK, S_DEL_WR, S_RESP
   } state_type;

   // memories
   logic [LW-1:0] head_mem [BUCKETS];
   logic [NW-1:0] tail_mem [BUCKETS];
   logic [VW-1:0] val_mem  [NODES];
   logic [LW-1:0] link_mem [NODES];
   logic          free_mem [NODES];
   logic [BUCKETS-1:0] head_vld_ff;

   state_type     state_ff;
   logic [1:0]    func_ff;
   logic [VW-1:0] value_ff;
   logic [BW-1:0] bkt_ff;
   logic [LW-1:0] head_rd_ff, cur_ff, prev_ff;
   logic [NW-1:0] tail_rd_ff, scan_ff;
   logic [VW-1:0] val_rd_ff;
   logic [LW-1:0] link_rd_ff;
   logic          free_rd_ff;
   logic [NW:0]   steps_ff;
   logic [1:0]    status_ff;
   logic [9:0]    bucket_ff;

   logic [BW-1:0] bkt_in;
   logic [LW-1:0] head_eff, link_eff, rd_node;

   assign bkt_in   = BW'(req_value % BUCKETS);
   assign head_eff = (!head_vld_ff[bkt_ff] || head_rd_ff >= LW'(NODES)) ?
                     LW'(NODES) : head_rd_ff;
   assign link_eff = (link_rd_ff >= LW'(NODES)) ? LW'(NODES) : link_rd_ff;
   // first node of a walk is addressed straight from the head read
   assign rd_node  = (state_ff == S_WALK_RD && steps_ff == '0) ? head_eff : cur_ff;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_bucket = bucket_ff;

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[bkt_ff];
      tail_rd_ff <= tail_mem[bkt_ff];
      val_rd_ff  <= val_mem[rd_node[NW-1:0]];
      link_rd_ff <= link_mem[rd_node[NW-1:0]];
      free_rd_ff <= free_mem[scan_ff];
      if (reset) begin
         state_ff    <= S_CLEAR;
         scan_ff     <= '0;
         head_vld_ff <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               free_mem[scan_ff] <= 1'b1;
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == NW'(NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  value_ff <= req_value;
                  bkt_ff   <= bkt_in;
                  scan_ff  <= '0;
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               // head/tail reads issued now, usable from the next state
               case (func_ff)
                  FUNC_INSERT: state_ff <= S_FREE_RD;
                  FUNC_SEARCH, FUNC_DELETE: begin
                     state_ff <= S_WALK_RD;
                     steps_ff <= '0;
                     prev_ff  <= LW'(NODES);
                  end
                  default: begin
                     status_ff <= ST_MISS;
                     bucket_ff <= '0;
                     state_ff  <= S_RESP;
                  end
               endcase
            end
            S_FREE_RD: state_ff <= S_FREE_CHK;
            S_FREE_CHK: begin
               if (free_rd_ff) begin
                  state_ff <= S_INS_WR;
               end else if (scan_ff == NW'(NODES - 1)) begin
                  status_ff <= ST_FULL;
                  bucket_ff <= '0;
                  state_ff  <= S_RESP;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_FREE_RD;
               end
            end
            S_INS_WR: begin
               free_mem[scan_ff] <= 1'b0;
               val_mem[scan_ff]  <= value_ff;
               link_mem[scan_ff] <= LW'(NODES);
               tail_mem[bkt_ff]  <= scan_ff;
               status_ff <= ST_DONE;
               bucket_ff <= 10'(bkt_ff);
               if (head_eff == LW'(NODES)) begin
                  head_mem[bkt_ff]    <= LW'(scan_ff);
                  head_vld_ff[bkt_ff] <= 1'b1;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_INS_LINK;
               end
            end
            S_INS_LINK: begin
               // tail_rd_ff still holds the old tail
               link_mem[tail_rd_ff] <= LW'(scan_ff);
               state_ff <= S_RESP;
            end
            S_WALK_RD: begin
               // first visit uses the head, later ones the link already in cur_ff
               if (steps_ff == '0) cur_ff <= head_eff;
               if ((steps_ff == '0 ? head_eff : cur_ff) == LW'(NODES) ||
                   steps_ff == (NW+1)'(NODES)) begin
                  status_ff <= ST_MISS;
                  bucket_ff <= '0;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_WALK_CHK;
               end
            end
            S_WALK_CHK: begin
               if (val_rd_ff == value_ff) begin
                  if (func_ff == FUNC_DELETE) begin
                     state_ff <= S_DEL_WR;
                  end else begin
                     status_ff <= ST_DONE;
                     bucket_ff <= 10'(bkt_ff);
                     state_ff  <= S_RESP;
                  end
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= link_eff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_WALK_RD;
               end
            end
            S_DEL_WR: begin
               if (prev_ff == LW'(NODES)) begin
                  head_mem[bkt_ff] <= link_eff;
               end else begin
                  link_mem[prev_ff[NW-1:0]] <= link_eff;
                  if (link_eff == LW'(NODES)) tail_mem[bkt_ff] <= prev_ff[NW-1:0];
               end
               free_mem[cur_ff[NW-1:0]] <= 1'b1;
               status_ff <= ST_DONE;
               bucket_ff <= 10'(bkt_ff);
               state_ff  <= S_RESP;
            end
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: sim/cht_checker.sv
// Checker for the chained hash table: mirrors the chained set, predicts each
// response and compares it with the block's output. Depends on cht_pkg.
module cht_checker
   import cht_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  logic [1:0]    req_func,
   input  logic [VW-1:0] req_value,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [1:0]    rsp_status,
   input  logic [9:0]    rsp_bucket,
   output int            fail_count,
   output int            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] bucket;
   } answer_type;

   // Chains are kept as ordered value lists per bucket; pool use is counted.
   logic [VW-1:0] chain_store [BUCKETS][$];
   int            nodes_used;
   answer_type    answer_queue [$];

   function automatic answer_type hash_set_apply(logic [1:0] func, logic [VW-1:0] value);
      answer_type a;
      int         b;
      int         hit;
      b = value % BUCKETS;
      hit = -1;
      for (int i = 0; i < chain_store[b].size(); i++)
         if (hit < 0 && chain_store[b][i] == value) hit = i;
      a.status = ST_MISS;
      a.bucket = '0;
      case (func)
         FUNC_INSERT: begin
            if (nodes_used >= NODES) begin
               a.status = ST_FULL;
            end else begin
               nodes_used++;
               chain_store[b].push_back(value);
               a.status = ST_DONE;
               a.bucket = 10'(b);
            end
         end
         FUNC_SEARCH: begin
            if (hit >= 0) begin
               a.status = ST_DONE;
               a.bucket = 10'(b);
            end
         end
         FUNC_DELETE: begin
            if (hit >= 0) begin
               chain_store[b].delete(hit);
               nodes_used--;
               a.status = ST_DONE;
               a.bucket = 10'(b);
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         foreach (chain_store[i]) chain_store[i].delete();
         nodes_used = 0;
         answer_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               $error("response transfer with nothing expected");
               errs++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_bucket !== want.bucket) begin
                  $error("bucket: expected %0d, got %0d", want.bucket, rsp_bucket);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            answer_queue.push_back(hash_set_apply(req_func, req_value));
         fail_count <= fail_count + errs;
         pending_count <= answer_queue.size();
      end
   end
endmodule

// File: sim/testbench.sv
// Top of the chained hash table testbench: clock, reset, request stimulus,
// response stalls and verdict. Depends on cht_pkg, chained_hash_table, cht_checker.
module testbench;
   import cht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [1:0]    req_func = FUNC_SEARCH;
   logic [VW-1:0] req_value = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_status;
   logic [9:0]    rsp_bucket;
   int            fail_count;
   int            pending_count;
   int            quiet_cycles = 0;
   bit            calm_phase = 1'b0;
   bit            hold_phase = 1'b0;
   logic [VW-1:0] recent_values [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   chained_hash_table uut (.*);

   cht_checker checker_inst (.*);

   // Response side: random stalls, a calm stretch and one long hold-off.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_phase) rsp_stall <= 1'b1;
      else rsp_stall <= !calm_phase && ($urandom_range(99) < 20);
   end

   initial begin
      wait (hold_phase);
      repeat (600) @(posedge clock);
      hold_phase = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] func, logic [VW-1:0] value);
      while (!calm_phase && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [VW-1:0] pick_value();
      logic [VW-1:0] v;
      case ($urandom_range(5))
         0: v = VW'($urandom);
         1: v = VW'(2 ** VW - 1 - $urandom_range(15));
         default: v = VW'($urandom_range(40));
      endcase
      if (recent_values.size() > 0 && $urandom_range(2) == 0)
         v = recent_values[$urandom_range(recent_values.size() - 1)];
      return v;
   endfunction

   initial begin
      logic [1:0]    f;
      logic [VW-1:0] v;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every operation, tail/head deletes, unknown func
      send_request(FUNC_SEARCH, 0);
      send_request(FUNC_DELETE, 5);
      send_request(FUNC_INSERT, 0);
      send_request(FUNC_INSERT, '1);
      send_request(FUNC_INSERT, 8);
      send_request(FUNC_INSERT, 16);
      send_request(FUNC_INSERT, 8);
      send_request(FUNC_SEARCH, '1);
      send_request(FUNC_SEARCH, 16);
      send_request(FUNC_DELETE, 16);
      send_request(FUNC_INSERT, 24);
      send_request(FUNC_DELETE, 0);
      send_request(FUNC_SEARCH, 8);
      send_request(FUNC_DELETE, 8);
      send_request(FUNC_SEARCH, 8);
      send_request(FUNC_UNUSED, '1);
      send_request(FUNC_DELETE, '1);
      // random: insert-heavy bursts to fill the pool, then drain phases
      for (int i = 0; i < 1250; i++) begin
         calm_phase = (i >= 300 && i < 420);
         if (i == 600) hold_phase = 1'b1;
         v = pick_value();
         case ($urandom_range(19))
            0: f = FUNC_UNUSED;
            1, 2, 3, 4, 5, 6: f = FUNC_SEARCH;
            default: f = ((i / 150) % 2 == 0) ? FUNC_INSERT : FUNC_DELETE;
         endcase
         if ($urandom_range(3) == 0) f = 2'(FUNC_SEARCH + $urandom_range(1));
         if (f == FUNC_INSERT) begin
            recent_values.push_back(v);
            if (recent_values.size() > 80) void'(recent_values.pop_front());
         end
         send_request(f, v);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
